### hdl/hsre_pkg.sv
`timescale 1ns / 1ps

package hsre_pkg;

  // Field and port widths.
  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned EDGE_W      = 15;
  localparam int unsigned SOC_W       = 11;
  localparam int unsigned SOC_Q_W     = 7;
  localparam int unsigned REM_W       = 7;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned IN_TUSER_W  = 2;
  localparam int unsigned OUT_TDATA_W = SPEED_W + 2 * COUNT_W;

  // Default depth of the moving-average window.
  localparam int unsigned WINDOW_DEPTH_DEF = 4;

  // Edge count saturates here so that three times the count fits in 16 bits.
  localparam logic [EDGE_W-1:0] EDGE_LIMIT = 15'd21845;

  // Charge in whole percent never goes above this.
  localparam logic [SOC_Q_W-1:0] SOC_Q_LIMIT = 7'd100;

  // Range is scaled by percent; the divisor and its reciprocal for small values.
  localparam logic [REM_W:0] DIV_CONST   = 8'd100;
  localparam int unsigned    RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int unsigned    RECIP_SHIFT = 19;
  localparam int unsigned    FIX_W       = 2 * SOC_Q_W + RECIP_W;

  // Reciprocal of 100 for a full 32-bit count: ceil(2^38 / 100), exact for any count.
  localparam logic [COUNT_W-1:0] DIV_RECIP = 32'd2748779070;
  localparam int unsigned        DIV_SHIFT = 38;

  // Item kinds carried on the input tuser.
  typedef enum logic [IN_TUSER_W-1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_RELOAD = 2'd2
  } action_t;

  // Full-range count split as quotient and remainder by 100.
  typedef struct packed {
    logic [COUNT_W-1:0] quot;
    logic [REM_W-1:0]   rem;
  } div_res_t;

endpackage

### hdl/hsre_div100.sv
`timescale 1ns / 1ps

module hsre_div100 (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [hsre_pkg::COUNT_W-1:0] dividend,
  output logic                         busy,
  output hsre_pkg::div_res_t           res
);
  import hsre_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 step_r, step_nxt;
  logic [COUNT_W-1:0]   dvd_r, dvd_nxt;
  logic [COUNT_W-1:0]   quot_r, quot_nxt;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [2*COUNT_W-1:0] q_prod;
  logic [COUNT_W-1:0]   q_back;

  // Quotient by reciprocal multiplication in the first busy cycle.
  assign q_prod = (2*COUNT_W)'(dvd_r) * (2*COUNT_W)'(DIV_RECIP);

  // The part of the count that the quotient covers; the rest is the remainder.
  assign q_back = quot_r * COUNT_W'(DIV_CONST);

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    if (busy_r) begin
      if (!step_r) begin
        quot_nxt = COUNT_W'(q_prod[2*COUNT_W-1:DIV_SHIFT]);
        step_nxt = 1'b1;
      end else begin
        rem_nxt  = REM_W'(dvd_r - q_back);
        busy_nxt = 1'b0;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 1'b0;
      dvd_nxt  = dividend;
    end
  end

  // Quotient and remainder reset to zero so an unconfigured range reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 1'b0;
      dvd_r  <= '0;
      quot_r <= '0;
      rem_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      dvd_r  <= dvd_nxt;
      quot_r <= quot_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign busy     = busy_r;
  assign res.quot = quot_r;
  assign res.rem  = rem_r;

endmodule

### hdl/hall_speed_and_range_estimator_unit.sv
`timescale 1ns / 1ps
// Hall speed and range estimator.
// Input channel (in_*): one transaction per item. in_tuser holds the item kind
// (sample the hall level, interval tick, reload the remaining range from the
// state of charge); in_tdata holds the hall level and the charge.
// Output channel (out_*): exactly one transaction per input item, in order,
// carrying the filtered speed, the running hall total and the remaining range
// as they stand after that item.
// Config channel (cfg_*): writes the full-charge range count. Each write starts
// a split of the count by 100 (reciprocal multiply, then remainder), and
// cfg_ready and in_tready stay low until the split is done.
// Throughput is one item per cycle while out_tready stays high and no split
// runs; a reload item holds in_tready low while its range product goes
// through a second register stage. After an input transaction the state
// registers update, then the output register loads and raises out_tvalid.
// When the receiver stalls, one finished result waits in the output register
// and one more in the state registers; then in_tready drops until out_tready.
// Reset clears the window, counters, range and configuration to zero.
module hall_speed_and_range_estimator_unit #(
  parameter int unsigned WINDOW_DEPTH = hsre_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [0] hall_level, [11:1] battery_soc, [15:12] zero
  input  logic [hsre_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] action
  input  logic [hsre_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [15:0] speed_filtered, [47:16] hall_total, [79:48] range_remaining
  output logic [hsre_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hsre_pkg::COUNT_W-1:0]     cfg_data
);
  import hsre_pkg::*;

  localparam int unsigned LG    = $clog2(WINDOW_DEPTH);
  localparam int unsigned SUM_W = SPEED_W + LG;
  localparam int unsigned SH    = SUM_W + LG;
  localparam int unsigned MUL_W = SUM_W + 2;
  localparam int unsigned PRD_W = SUM_W + MUL_W;
  localparam longint unsigned MEAN_RECIP_L =
    ((64'd1 << SH) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
  localparam logic [MUL_W-1:0] MEAN_M = MUL_W'(MEAN_RECIP_L);

  // Input fields.
  action_t            act;
  logic               in_lvl;
  logic [SOC_W-1:0]   in_soc;
  logic               in_fire;
  logic               cfg_fire;

  // Configuration split.
  logic               div_busy;
  div_res_t           div_res;

  // State.
  logic               last_level_r, last_level_nxt;
  logic [EDGE_W-1:0]  edge_count_r, edge_count_nxt;
  logic [SPEED_W-1:0] hist_r [WINDOW_DEPTH];
  logic [SPEED_W-1:0] hist_nxt [WINDOW_DEPTH];
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt;
  logic [COUNT_W-1:0] remaining_r, remaining_nxt;

  // Pipeline control.
  logic               v1_r, v1_nxt;
  logic               rl_pend_r, rl_pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_load;

  // Reload products.
  logic [COUNT_W-1:0]   qa_r;
  logic [2*SOC_Q_W-1:0] qb_r;
  logic [COUNT_W+SOC_Q_W-1:0] qa_wide;
  logic [2*SOC_Q_W-1:0] qb_wide;
  logic [FIX_W-1:0]     fix_prod;
  logic [REM_W-1:0]     fix;
  logic [SOC_Q_W-1:0]   soc_sh, soc_q;

  // Tick arithmetic.
  logic [SPEED_W:0]   per_wide;
  logic [SPEED_W-1:0] per;

  // Output stage.
  logic [PRD_W-1:0]   mean_prod;
  logic [SPEED_W-1:0] out_speed_r;
  logic [COUNT_W-1:0] out_total_r;
  logic [COUNT_W-1:0] out_range_r;

  assign act      = action_t'(in_tuser);
  assign in_lvl   = in_tdata[0];
  assign in_soc   = in_tdata[SOC_W:1];
  assign in_fire  = in_tvalid & in_tready;
  assign cfg_fire = cfg_valid & cfg_ready;

  hsre_div100 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cfg_fire),
    .dividend (cfg_data),
    .busy     (div_busy),
    .res      (div_res)
  );

  // Per-interval full-hall changes: three times the single-hall edge count.
  assign per_wide = {1'b0, edge_count_r, 1'b0} + {2'b00, edge_count_r};
  assign per      = per_wide[SPEED_W-1:0];

  // Whole percent of charge, clamped to 100.
  assign soc_sh  = in_soc[SOC_W-1:4];
  assign soc_q   = (soc_sh > SOC_Q_LIMIT) ? SOC_Q_LIMIT : soc_sh;
  assign qa_wide = (COUNT_W+SOC_Q_W)'(soc_q) * (COUNT_W+SOC_Q_W)'(div_res.quot);
  assign qb_wide = (2*SOC_Q_W)'(soc_q) * (2*SOC_Q_W)'(div_res.rem);

  // floor(q*rem/100) by reciprocal; the product stays below 10000.
  assign fix_prod = FIX_W'(qb_r) * FIX_W'(RECIP_100);
  assign fix      = fix_prod[RECIP_SHIFT +: REM_W];

  // State update for the accepted item.
  always_comb begin
    last_level_nxt = last_level_r;
    edge_count_nxt = edge_count_r;
    hist_nxt       = hist_r;
    sum_nxt        = sum_r;
    total_nxt      = total_r;
    remaining_nxt  = remaining_r;
    if (rl_pend_r) begin
      remaining_nxt = qa_r + COUNT_W'(fix);
    end
    if (in_fire) begin
      unique case (act)
        ACT_SAMPLE: begin
          if (in_lvl != last_level_r) begin
            last_level_nxt = in_lvl;
            if (edge_count_r < EDGE_LIMIT) begin
              edge_count_nxt = edge_count_r + 1'b1;
            end
          end
        end
        ACT_TICK: begin
          total_nxt = total_r + COUNT_W'(per);
          sum_nxt   = sum_r - SUM_W'(hist_r[0]) + SUM_W'(per);
          for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
            hist_nxt[k] = hist_r[k+1];
          end
          hist_nxt[WINDOW_DEPTH-1] = per;
          remaining_nxt = (remaining_r > COUNT_W'(per)) ?
                          (remaining_r - COUNT_W'(per)) : '0;
          edge_count_nxt = '0;
        end
        ACT_RELOAD: begin
          total_nxt = '0;
        end
        default: ;
      endcase
    end
  end

  // Pipeline control: the state holds one result until the output register takes it.
  assign out_load  = v1_r & (~out_valid_r | out_tready);
  assign in_tready = ~div_busy & ~rl_pend_r & (~v1_r | out_load);
  assign cfg_ready = ~div_busy;

  always_comb begin
    rl_pend_nxt = 1'b0;
    if (in_fire) begin
      v1_nxt      = (act != ACT_RELOAD);
      rl_pend_nxt = (act == ACT_RELOAD);
    end else if (rl_pend_r) begin
      v1_nxt = 1'b1;
    end else if (out_load) begin
      v1_nxt = 1'b0;
    end else begin
      v1_nxt = v1_r;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
      edge_count_r <= '0;
      hist_r       <= '{default: '0};
      sum_r        <= '0;
      total_r      <= '0;
      remaining_r  <= '0;
      v1_r         <= 1'b0;
      rl_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      last_level_r <= last_level_nxt;
      edge_count_r <= edge_count_nxt;
      hist_r       <= hist_nxt;
      sum_r        <= sum_nxt;
      total_r      <= total_nxt;
      remaining_r  <= remaining_nxt;
      v1_r         <= v1_nxt;
      rl_pend_r    <= rl_pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Reload products, finished in the following cycle.
  always_ff @(posedge clk) begin
    if (in_fire && (act == ACT_RELOAD)) begin
      qa_r <= qa_wide[COUNT_W-1:0];
      qb_r <= qb_wide;
    end
  end

  // Window mean by reciprocal multiplication, taken into the output register.
  assign mean_prod = PRD_W'(sum_r) * PRD_W'(MEAN_M);

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_speed_r <= mean_prod[SH +: SPEED_W];
      out_total_r <= total_r;
      out_range_r <= remaining_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_range_r, out_total_r, out_speed_r};

  // A reload is followed by its reload stage, with no result pending yet.
  a_reload_pend : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (act == ACT_RELOAD) |=> rl_pend_r && !v1_r)
    else $error("reload did not enter its second stage");

  // Outside the reload stage the remaining range never grows.
  a_range_falls : assert property (@(posedge clk) disable iff (!rst_n)
    !rl_pend_r |=> remaining_r <= $past(remaining_r))
    else $error("remaining range grew without a reload");

  // State is frozen while its result waits for the output register.
  a_state_held : assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !out_load |=> $stable(total_r) && $stable(remaining_r) && $stable(sum_r))
    else $error("state changed under a pending result");

  // No item or write is taken while the range split runs.
  a_div_block : assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> !in_tready && !cfg_ready)
    else $error("transaction accepted during range split");

endmodule

### verif/hsre_checker.sv
`timescale 1ns / 1ps

// Watches the input, configuration and result channels of the hall speed and
// range estimator. Every accepted input transaction is run through a local
// model of the estimator, and every result transaction is compared with the
// oldest estimate still waiting.
module hsre_checker
  import hsre_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [COUNT_W-1:0]     cfg_data,
  output int                     outstanding,
  output int                     mismatches
);

  // Scaling constants of the range and speed arithmetic.
  localparam int unsigned CHANGES_PER_EDGE = 3;
  localparam int unsigned SOC_PER_PERCENT  = 16;
  localparam int unsigned PERCENT_FULL     = 100;
  localparam int unsigned SOC_MAX          = 1600;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic [COUNT_W-1:0] total;
    logic [COUNT_W-1:0] range;
  } estimate_t;

  // Local copy of the estimator state.
  logic               seen_level;
  logic [EDGE_W-1:0]  edge_tally;
  logic [SPEED_W-1:0] speed_window [WINDOW_DEPTH];
  logic [COUNT_W-1:0] change_total;
  logic [COUNT_W-1:0] range_left;
  logic [SPEED_W-1:0] speed_mean;
  logic [COUNT_W-1:0] full_charge_range;

  estimate_t expected_estimates [$];
  int        errors;

  assign mismatches = errors;

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  // Clears the local state to its reset values.
  task automatic clear_estimator();
    seen_level        = 1'b0;
    edge_tally        = '0;
    change_total      = '0;
    range_left        = '0;
    speed_mean        = '0;
    full_charge_range = '0;
    for (int k = 0; k < WINDOW_DEPTH; k++) speed_window[k] = '0;
  endtask

  // Applies one input item to the local state and returns the outputs after it.
  function automatic estimate_t estimate_after(input logic [IN_TUSER_W-1:0] act,
                                               input logic lvl,
                                               input logic [SOC_W-1:0] soc);
    logic [SPEED_W-1:0] per_interval;
    logic [31:0]        window_sum;
    logic [SOC_W-1:0]   soc_clamped;
    logic [63:0]        product;
    estimate_t          res;
    case (act)
      ACT_SAMPLE: begin
        if (lvl != seen_level) begin
          seen_level = lvl;
          if (edge_tally < EDGE_LIMIT) edge_tally = edge_tally + 1'b1;
        end
      end
      ACT_TICK: begin
        per_interval = SPEED_W'(32'(edge_tally) * CHANGES_PER_EDGE);
        change_total = change_total + COUNT_W'(per_interval);
        window_sum   = '0;
        for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
          speed_window[k] = speed_window[k + 1];
          window_sum      = window_sum + 32'(speed_window[k]);
        end
        speed_window[WINDOW_DEPTH - 1] = per_interval;
        window_sum = window_sum + 32'(per_interval);
        speed_mean = SPEED_W'(window_sum / WINDOW_DEPTH);
        // Range floors at zero once the interval covers what is left.
        if (range_left > COUNT_W'(per_interval))
          range_left = range_left - COUNT_W'(per_interval);
        else
          range_left = '0;
        edge_tally = '0;
      end
      ACT_RELOAD: begin
        soc_clamped  = (soc > SOC_MAX) ? SOC_W'(SOC_MAX) : soc;
        product      = 64'(soc_clamped / SOC_PER_PERCENT) * 64'(full_charge_range);
        range_left   = COUNT_W'(product / PERCENT_FULL);
        change_total = '0;
      end
      default: begin
        // The unused kind leaves the state alone.
      end
    endcase
    res.speed = speed_mean;
    res.total = change_total;
    res.range = range_left;
    return res;
  endfunction

  // Compares one result transaction with the oldest waiting estimate.
  task automatic check_result(input logic [OUT_TDATA_W-1:0] data);
    estimate_t want;
    estimate_t got;
    got.speed = data[SPEED_W-1:0];
    got.total = data[SPEED_W+COUNT_W-1:SPEED_W];
    got.range = data[SPEED_W+2*COUNT_W-1:SPEED_W+COUNT_W];
    if (expected_estimates.size() == 0) begin
      $display("%0t: result with no item waiting, actual speed %0d total %0d range %0d",
               $time, got.speed, got.total, got.range);
      errors++;
    end else begin
      want = expected_estimates.pop_front();
      if (got.speed !== want.speed) begin
        $display("%0t: speed_filtered mismatch, expected %0d, actual %0d",
                 $time, want.speed, got.speed);
        errors++;
      end
      if (got.total !== want.total) begin
        $display("%0t: hall_total mismatch, expected %0d, actual %0d",
                 $time, want.total, got.total);
        errors++;
      end
      if (got.range !== want.range) begin
        $display("%0t: range_remaining mismatch, expected %0d, actual %0d",
                 $time, want.range, got.range);
        errors++;
      end
    end
  endtask

  // Channel monitor: configuration, results and input transactions.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_estimator();
      expected_estimates.delete();
    end else begin
      if (cfg_valid && cfg_ready) full_charge_range = cfg_data;
      if (out_tvalid && out_tready) check_result(out_tdata);
      if (in_tvalid && in_tready)
        expected_estimates.push_back(estimate_after(in_tuser, in_tdata[0],
                                                    in_tdata[SOC_W:1]));
    end
    outstanding <= expected_estimates.size();
  end

endmodule

### verif/tb_hall_speed_and_range_estimator_unit.sv
`timescale 1ns / 1ps

// Drives items and range settings into the estimator and gives the verdict.
module tb_hall_speed_and_range_estimator_unit;
  import hsre_pkg::*;

  // Item kind that the block leaves alone.
  localparam logic [IN_TUSER_W-1:0] ACT_UNUSED = 2'd3;

  // Receiver behaviors.
  localparam int RX_OPEN     = 0;
  localparam int RX_LIGHT    = 1;
  localparam int RX_HEAVY    = 2;
  localparam int RX_PERIODIC = 3;

  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SOC_TOP     = 2047;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [COUNT_W-1:0]     cfg_data;

  int outstanding;
  int mismatches;
  int cycles;
  int burst_left;
  int hold_requests;
  int holds_done;
  logic lvl_now;

  hall_speed_and_range_estimator_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  hsre_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // 2 ns clock.
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog on the whole run.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sends one item as an input transaction; the sender runs in bursts with gaps.
  // Entered and left just after a falling edge.
  task automatic send_item(input logic [IN_TUSER_W-1:0] act, input logic lvl,
                           input logic [SOC_W-1:0] soc);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{(IN_TDATA_W - SOC_W - 1){1'b0}}, soc, lvl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic stop_items();
    in_tvalid  <= 1'b0;
    burst_left = 0;
  endtask

  // Writes the full-charge range once the block has drained.
  task automatic write_range(input logic [COUNT_W-1:0] value);
    stop_items();
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SOC_W-1:0] pick_soc();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return SOC_W'(1600);
      2:       return SOC_W'($urandom_range(1601, SOC_TOP));
      3:       return SOC_W'(SOC_TOP);
      4:       return SOC_W'($urandom_range(0, 31));
      default: return SOC_W'($urandom_range(0, 1600));
    endcase
  endfunction

  // Mostly hall sample runs broken by ticks, with reloads and unused kinds mixed in.
  task automatic random_traffic(input int count, input int tick_pct);
    int roll;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 95 - tick_pct) begin
        lvl_now = ($urandom_range(0, 9) < 7) ? ~lvl_now : 1'($urandom_range(0, 1));
        send_item(ACT_SAMPLE, lvl_now, SOC_W'($urandom_range(0, SOC_TOP)));
      end else if (roll < 95) begin
        send_item(ACT_TICK, 1'($urandom_range(0, 1)), SOC_W'($urandom_range(0, SOC_TOP)));
      end else if (roll < 98) begin
        send_item(ACT_RELOAD, 1'($urandom_range(0, 1)), pick_soc());
      end else begin
        send_item(ACT_UNUSED, 1'($urandom_range(0, 1)), SOC_W'($urandom_range(0, SOC_TOP)));
      end
    end
  endtask

  // Receiver: changing stall patterns, plus long hold-offs on request.
  initial begin
    int mode;
    int mode_left;
    int beat;
    out_tready = 1'b0;
    mode       = RX_OPEN;
    mode_left  = 0;
    beat       = 0;
    holds_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(RX_OPEN, RX_PERIODIC);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RX_OPEN:  out_tready <= 1'b1;
          RX_LIGHT: out_tready <= ($urandom_range(0, 3) != 0);
          RX_HEAVY: out_tready <= ($urandom_range(0, 9) < 3);
          default: begin
            out_tready <= (beat % 5 != 0);
            beat++;
          end
        endcase
      end
    end
  end

  // Main sequence.
  initial begin
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = ACT_SAMPLE;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    rst_n         = 1'b0;
    burst_left    = 0;
    hold_requests = 0;
    lvl_now       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset state: unused kind, reload with a zero range, empty tick.
    send_item(ACT_UNUSED, 1'b1, SOC_W'(SOC_TOP));
    send_item(ACT_RELOAD, 1'b0, SOC_W'(1600));
    send_item(ACT_TICK, 1'b0, '0);

    // Largest range: full charge, clamped charge, thresholds of one percent.
    write_range(32'hFFFF_FFFF);
    send_item(ACT_RELOAD, 1'b0, SOC_W'(1600));
    send_item(ACT_SAMPLE, 1'b1, '0);
    send_item(ACT_SAMPLE, 1'b1, SOC_W'(SOC_TOP));
    send_item(ACT_SAMPLE, 1'b0, '0);
    send_item(ACT_SAMPLE, 1'b1, '0);
    send_item(ACT_TICK, 1'b0, '0);
    send_item(ACT_RELOAD, 1'b1, SOC_W'(SOC_TOP));
    send_item(ACT_RELOAD, 1'b0, SOC_W'(16));
    send_item(ACT_RELOAD, 1'b0, SOC_W'(15));
    // Tick with an empty range stays at zero.
    send_item(ACT_SAMPLE, 1'b0, '0);
    send_item(ACT_SAMPLE, 1'b1, '0);
    send_item(ACT_TICK, 1'b1, SOC_W'(SOC_TOP));
    send_item(ACT_UNUSED, 1'b0, '0);
    send_item(ACT_RELOAD, 1'b0, SOC_W'(1599));
    send_item(ACT_SAMPLE, 1'b0, '0);
    send_item(ACT_SAMPLE, 1'b1, '0);
    send_item(ACT_SAMPLE, 1'b0, '0);
    send_item(ACT_TICK, 1'b0, '0);
    send_item(ACT_TICK, 1'b0, '0);
    send_item(ACT_TICK, 1'b0, '0);
    send_item(ACT_TICK, 1'b0, '0);
    lvl_now = 1'b0;

    // Random phases over several range settings.
    write_range('0);
    hold_requests++;
    random_traffic(230, 12);
    write_range(32'hFFFF_FFFF);
    random_traffic(230, 10);
    write_range(COUNT_W'($urandom_range(1, 500)));
    hold_requests++;
    random_traffic(230, 15);
    write_range(COUNT_W'(100));
    random_traffic(230, 12);
    write_range(COUNT_W'($urandom()));
    random_traffic(230, 5);
    write_range(32'h8000_0000);
    random_traffic(230, 20);

    // A last random phase after a full-charge reload.
    write_range(COUNT_W'($urandom()));
    send_item(ACT_RELOAD, 1'b0, SOC_W'(1600));
    random_traffic(40, 12);

    // Drain and give the verdict.
    stop_items();
    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/hsre_pkg.sv
hdl/hsre_div100.sv
hdl/hall_speed_and_range_estimator_unit.sv
verif/hsre_checker.sv
verif/tb_hall_speed_and_range_estimator_unit.sv
